FILE: rtl/core/pafrf_pkg.sv
// ----------------------------------------------------------------------------
// pafrf_pkg
// Shared types and constants for the PS/2 receive queue with ACK filter.
// ----------------------------------------------------------------------------
package pafrf_pkg;

  typedef enum logic [1:0] {
    FUNC_RX    = 2'd0,
    FUNC_SEND  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_FLUSH = 2'd3
  } func_t;

  typedef logic [7:0] byte_t;

  localparam byte_t ACK_CODE  = 8'hFA;
  localparam byte_t ACK_MAX   = 8'hFF;

endpackage

FILE: rtl/core/pafrf_if.sv
// ----------------------------------------------------------------------------
// pafrf_if
// Valid/ready channels for operation words in and result words out.
// ----------------------------------------------------------------------------
interface pafrf_in_if;
  import pafrf_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  byte_t data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface pafrf_out_if;
  import pafrf_pkg::*;

  logic  valid;
  logic  ready;
  byte_t read_byte;
  logic  read_valid;
  byte_t send_byte;
  logic  send_valid;
  logic  ack_swallowed;
  logic  byte_dropped;
  logic  ring_empty;

  modport source (output valid, output read_byte, output read_valid, output send_byte,
                  output send_valid, output ack_swallowed, output byte_dropped,
                  output ring_empty, input ready);
  modport sink   (input valid, input read_byte, input read_valid, input send_byte,
                  input send_valid, input ack_swallowed, input byte_dropped,
                  input ring_empty, output ready);
endinterface

FILE: rtl/core/ps2_ack_filter_rx_fifo.sv
// ----------------------------------------------------------------------------
// ps2_ack_filter_rx_fifo
// PS/2 receive ring buffer with filtering of expected ACK bytes.
// ----------------------------------------------------------------------------
// One operation word is taken per cycle and its result word appears in the
// output register on the next cycle; the input stays ready while that
// register is empty or being drained, so a sink that always takes results
// sees one word per clock. The single-port read of the byte memory
// (registered on the accept edge) supplies the read byte. The ring has
// DEPTH slots and holds at most DEPTH-1 bytes; the memory is not cleared,
// since only written slots are ever read. The user must write capture_enable
// only while no word is in flight; the block itself does not enforce it.
module ps2_ack_filter_rx_fifo #(
  parameter int DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  pafrf_in_if.sink    in_ch,
  pafrf_out_if.source out_ch
);
  import pafrf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef logic [AW-1:0] idx_t;

  logic  capture_enable;
  idx_t  write_index, write_index_next;
  idx_t  read_index, read_index_next;
  byte_t acks_pending, acks_pending_next;

  byte_t mem [DEPTH];
  byte_t mem_q;
  logic  mem_we, mem_re;

  logic  accept;
  idx_t  wr_inc, rd_inc;
  logic  not_empty;

  logic  res_valid;
  logic  res_read_valid;
  byte_t res_send_byte;
  logic  res_send_valid;
  logic  res_swallowed;
  logic  res_dropped;
  logic  res_empty;

  logic  rd_ok, swallow, drop;

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign wr_inc    = (write_index == LAST) ? '0 : write_index + 1'b1;
  assign rd_inc    = (read_index == LAST) ? '0 : read_index + 1'b1;
  assign not_empty = (read_index != write_index);

  always_comb begin
    write_index_next  = write_index;
    read_index_next   = read_index;
    acks_pending_next = acks_pending;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    rd_ok             = 1'b0;
    swallow           = 1'b0;
    drop              = 1'b0;
    unique case (in_ch.func)
      FUNC_RX: begin
        if (acks_pending != '0 && in_ch.data_byte == ACK_CODE) begin
          acks_pending_next = acks_pending - 1'b1;
          swallow           = 1'b1;
        end else begin
          acks_pending_next = '0;
          if (capture_enable && wr_inc != read_index) begin
            mem_we           = accept;
            write_index_next = wr_inc;
          end else begin
            drop = 1'b1;
          end
        end
      end
      FUNC_SEND: begin
        if (acks_pending != ACK_MAX) acks_pending_next = acks_pending + 1'b1;
      end
      FUNC_READ: begin
        if (not_empty) begin
          rd_ok           = 1'b1;
          mem_re          = accept;
          read_index_next = rd_inc;
        end
      end
      FUNC_FLUSH: begin
        write_index_next = '0;
        read_index_next  = '0;
      end
      default: ;
    endcase
  end

  // byte memory: one write or one registered read per word
  always_ff @(posedge clk) begin
    if (mem_we) mem[write_index] <= in_ch.data_byte;
    if (mem_re) mem_q <= mem[read_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
      write_index    <= '0;
      read_index     <= '0;
      acks_pending   <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) capture_enable <= cfg_wdata;
      if (accept) begin
        write_index  <= write_index_next;
        read_index   <= read_index_next;
        acks_pending <= acks_pending_next;
        res_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_read_valid <= rd_ok;
      res_send_valid <= (in_ch.func == FUNC_SEND);
      res_send_byte  <= (in_ch.func == FUNC_SEND) ? in_ch.data_byte : '0;
      res_swallowed  <= swallow;
      res_dropped    <= drop;
      res_empty      <= (write_index_next == read_index_next);
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.read_byte     = res_read_valid ? mem_q : '0;
  assign out_ch.read_valid    = res_read_valid;
  assign out_ch.send_byte     = res_send_byte;
  assign out_ch.send_valid    = res_send_valid;
  assign out_ch.ack_swallowed = res_swallowed;
  assign out_ch.byte_dropped  = res_dropped;
  assign out_ch.ring_empty    = res_empty;

endmodule

FILE: rtl/core/pafrf_chk.sv
// ----------------------------------------------------------------------------
// pafrf_chk
// Port-level checks for the PS/2 receive queue, bound to the top level.
// ----------------------------------------------------------------------------
module pafrf_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_read_valid,
  input logic       out_ring_empty
);
  import pafrf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // nothing left over from before reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // every accepted word yields its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted word produced no result");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_func == FUNC_FLUSH |=> out_ring_empty)
    else $error("queue not empty after flush");

  // a read with nothing queued cannot return a byte; the drained word must be
  // the last one taken, so no word may enter in the same cycle
  a_read_after_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_ring_empty && !in_acc ##1 in_acc && in_func == FUNC_READ
      |=> !out_read_valid)
    else $error("read returned a byte from an empty queue");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

endmodule

bind ps2_ack_filter_rx_fifo pafrf_chk u_pafrf_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_func         (in_ch.func),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_read_valid  (out_ch.read_valid),
  .out_ring_empty  (out_ch.ring_empty)
);

FILE: verif/ps2_ack_filter_rx_fifo_tb.sv
// ----------------------------------------------------------------------------
// ps2_ack_filter_rx_fifo_tb
// Drives receive, command, read and flush words into the PS/2 receive queue
// with random sender bursts and receiver stalls. A scoreboard tracks the ring,
// the pending-ACK count and the capture bit, and checks each result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_ack_filter_rx_fifo_tb;
  import pafrf_pkg::*;

  localparam int RING_DEPTH  = 2048;
  localparam int RANDOM_OPS  = 970;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    byte_t read_byte;
    logic  read_valid;
    byte_t send_byte;
    logic  send_valid;
    logic  ack_swallowed;
    logic  byte_dropped;
    logic  ring_empty;
  } result_t;

  typedef enum {SINK_FREE, SINK_TOGGLE, SINK_COIN, SINK_SLOW} sink_mode_t;

  class rx_queue_tracker;
    byte_t   ring [RING_DEPTH];
    int      wr_ptr;
    int      rd_ptr;
    int      acks_owed;
    bit      capture;
    int      mismatches;
    result_t due_words [$];

    function new();
      wr_ptr     = 0;
      rd_ptr     = 0;
      acks_owed  = 0;
      capture    = 1'b0;
      mismatches = 0;
    endfunction

    function int ring_step(int idx);
      return (idx == RING_DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function void note_op(func_t f, byte_t d);
      result_t r;
      r = '0;
      case (f)
        FUNC_RX: begin
          if (acks_owed != 0 && d == ACK_CODE) begin
            acks_owed--;
            r.ack_swallowed = 1'b1;
          end else begin
            acks_owed = 0;
            if (capture && ring_step(wr_ptr) != rd_ptr) begin
              ring[wr_ptr] = d;
              wr_ptr = ring_step(wr_ptr);
            end else begin
              r.byte_dropped = 1'b1;
            end
          end
        end
        FUNC_SEND: begin
          r.send_byte  = d;
          r.send_valid = 1'b1;
          if (acks_owed < int'(ACK_MAX)) acks_owed++;
        end
        FUNC_READ: begin
          if (rd_ptr != wr_ptr) begin
            r.read_byte  = ring[rd_ptr];
            r.read_valid = 1'b1;
            rd_ptr = ring_step(rd_ptr);
          end
        end
        default: begin
          wr_ptr = 0;
          rd_ptr = 0;
        end
      endcase
      r.ring_empty = (wr_ptr == rd_ptr);
      due_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        $display("%0t: result word with none expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      compare_field("send_byte", want.send_byte, got.send_byte);
      compare_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
      compare_field("ack_swallowed", 8'(want.ack_swallowed), 8'(got.ack_swallowed));
      compare_field("byte_dropped", 8'(want.byte_dropped), 8'(got.byte_dropped));
      compare_field("ring_empty", 8'(want.ring_empty), 8'(got.ring_empty));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  pafrf_in_if  in_ch ();
  pafrf_out_if out_ch ();

  rx_queue_tracker board;
  int ops_sent   = 0;
  int burst_left = 0;

  ps2_ack_filter_rx_fifo #(.DEPTH(RING_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  task automatic push_op(func_t f, byte_t d);
    int gap_n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap_n) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.func      = f;
    in_ch.data_byte = d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_op(f, d);
    ops_sent++;
  endtask

  // hold off the sender until every result word is back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capture(bit en);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = en;
    @(negedge clk);
    cfg_we    = 1'b0;
    board.capture = en;
  endtask

  task automatic run_episode();
    int kind;
    int n;
    int i;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // host commands answered by ACKs, now and then a stray byte instead
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_op(FUNC_SEND, byte_t'($urandom));
      for (i = 0; i < n; i++)
        push_op(FUNC_RX, ($urandom_range(0, 9) == 0) ? byte_t'($urandom) : ACK_CODE);
    end else if (kind < 70) begin
      // motion packet, then the reader drains some of it
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
        push_op(FUNC_RX, ($urandom_range(0, 7) == 0) ? ACK_CODE : byte_t'($urandom));
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) push_op(FUNC_READ, byte_t'($urandom));
    end else if (kind < 96) begin
      push_op(func_t'($urandom_range(0, 3)), byte_t'($urandom));
    end else begin
      push_op(FUNC_FLUSH, byte_t'($urandom));
    end
  endtask

  initial begin
    sink_mode_t mode;
    int left;
    out_ch.ready = 1'b0;
    mode = SINK_FREE;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        SINK_FREE:   out_ch.ready = 1'b1;
        SINK_TOGGLE: out_ch.ready = ~out_ch.ready;
        SINK_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
        default:     out_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_word(result_t'({out_ch.read_byte, out_ch.read_valid, out_ch.send_byte,
                                  out_ch.send_valid, out_ch.ack_swallowed,
                                  out_ch.byte_dropped, out_ch.ring_empty}));
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int i;
    int start_ops;
    int next_cfg;
    board           = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_RX;
    in_ch.data_byte = 8'h00;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // capture off after reset: bytes discarded, ACK filter still active
    push_op(FUNC_RX, 8'h00);
    push_op(FUNC_READ, 8'hFF);
    push_op(FUNC_SEND, 8'h00);
    push_op(FUNC_RX, ACK_CODE);
    push_op(FUNC_RX, ACK_CODE);
    write_capture(1'b1);
    push_op(FUNC_RX, 8'hFF);
    push_op(FUNC_RX, 8'h00);
    push_op(FUNC_READ, 8'h00);
    push_op(FUNC_READ, 8'h00);
    push_op(FUNC_READ, 8'hFF);
    push_op(FUNC_SEND, 8'hFF);
    push_op(FUNC_SEND, 8'hA5);
    push_op(FUNC_RX, ACK_CODE);
    push_op(FUNC_RX, 8'h12);
    push_op(FUNC_RX, ACK_CODE);
    push_op(FUNC_SEND, 8'hF4);
    push_op(FUNC_FLUSH, 8'hFF);
    push_op(FUNC_READ, 8'h00);
    push_op(FUNC_RX, ACK_CODE);
    push_op(FUNC_RX, 8'h5A);
    push_op(FUNC_READ, 8'h00);

    // pending-ACK count saturates, then one ACK too many gets queued
    for (i = 0; i < 300; i++) push_op(FUNC_SEND, byte_t'($urandom));
    for (i = 0; i < 256; i++) push_op(FUNC_RX, ACK_CODE);

    start_ops = ops_sent;
    next_cfg  = ops_sent + $urandom_range(150, 350);
    while (ops_sent - start_ops < RANDOM_OPS) begin
      run_episode();
      if (ops_sent >= next_cfg) begin
        write_capture($urandom_range(0, 3) != 0);
        next_cfg = ops_sent + $urandom_range(150, 350);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
